FILE: rtl/rmsn_pkg.sv
// shared constants, types and handshake structs for the rms normalisation block
`timescale 1ns / 1ps

package rmsn_pkg;

  localparam int MAX_LEN   = 64;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int SUM_W     = 37;
  localparam int ROOT_W    = 19;
  localparam int INV_W     = 29;
  localparam int DIV_STEPS = SUM_W;
  localparam int ROOT_STEPS = ROOT_W;

  localparam logic [15:0]      EPS_RESET = 16'd168;
  localparam logic [SUM_W-1:0] RECIP_NUM = SUM_W'(64'd1 << 28);

  localparam logic signed [31:0] SAT_MAX = 32'sd32767;
  localparam logic signed [31:0] SAT_MIN = -32'sd32768;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FLUSH,
    ST_MEAN,
    ST_ROOT,
    ST_RECIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [ROOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

FILE: rtl/rms_normalize_vector.sv
// top level of the fixed-point rms normalisation block
`timescale 1ns / 1ps

// rms normalisation of one vector of up to 64 (x, gain) pairs, x in q3.12 and
// gain in q1.14. pairs load at one request per cycle into a 64-entry pair
// memory while the sum of squares builds up; a request marked is_last, or the
// 64th request, closes the vector. the block then stalls its input and works
// out m = floor(sum / n) + epsilon, s = floor(sqrt(m)) (a zero root counts as
// one) and inv = floor(2^28 / s). after that every stored pair is read back
// in load order and gives out_val = clamp((x * gain * inv) >> 30) with an
// arithmetic shift; the final result carries out_last. a vector passes
// through loading, a flush state, the mean on the shared restoring divider,
// the root, the reciprocal on the same divider and then the results, given
// out at one per cycle while the output does not stall, behind a four-stage
// read/multiply pipeline. the next vector is accepted in the cycle after the
// final result is taken. epsilon (units of 2^-24, reset 168) should only be
// written while no vector is in flight.

module rms_normalize_vector
  import rmsn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] x_val,
  input  logic signed [15:0] gain_val,
  input  logic               is_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_val,
  output logic               out_last
);

  state_t state, state_next;

  logic [15:0]      epsilon;
  logic [CNT_W-1:0] elem_count;
  logic [SUM_W-1:0] square_sum;
  logic [SUM_W-1:0] square_sum_next;
  logic [30:0]      sq;
  logic             sq_valid;
  logic signed [31:0] sq_full;

  logic in_accept;
  logic last_eff;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  logic              emit_start;
  logic              emit_done;
  logic [INV_W-1:0]  emit_inv;
  logic [ROOT_W-1:0] root_fix;

  // request handshake on the input side
  assign in_accept = in_valid && !in_stall;
  // a full vector closes even without the last mark
  assign last_eff  = is_last || (elem_count == CNT_W'(MAX_LEN - 1));

  // square is registered, then folded into the running sum in the cycle after
  assign sq_full         = x_val * x_val;
  assign square_sum_next = sq_valid ? square_sum + SUM_W'(sq) : square_sum;

  // zero root only reachable with epsilon written as zero
  assign root_fix = (sqrt_rsp.root == '0) ? ROOT_W'(1) : sqrt_rsp.root;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (in_accept && last_eff) state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_MEAN;
      ST_MEAN:  if (div_rsp.done) state_next = ST_ROOT;
      ST_ROOT:  if (sqrt_rsp.done) state_next = ST_RECIP;
      ST_RECIP: if (div_rsp.done) state_next = ST_EMIT;
      ST_EMIT:  if (emit_done) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // outputs and unit requests
  always_comb begin
    in_stall          = 1'b1;
    div_req.start     = 1'b0;
    div_req.dividend  = RECIP_NUM;
    div_req.divisor   = root_fix;
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = div_rsp.quotient + SUM_W'(epsilon);
    emit_start        = 1'b0;
    emit_inv          = div_rsp.quotient[INV_W-1:0];
    unique case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
      end
      ST_FLUSH: begin
        // mean: sum over count, last square folded in on the fly
        div_req.start    = 1'b1;
        div_req.dividend = square_sum_next;
        div_req.divisor  = ROOT_W'(elem_count);
      end
      ST_MEAN: begin
        sqrt_req.start = div_rsp.done;
      end
      ST_ROOT: begin
        // reciprocal of the root
        div_req.start = sqrt_rsp.done;
      end
      ST_RECIP: begin
        emit_start = div_rsp.done;
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      epsilon    <= EPS_RESET;
      elem_count <= '0;
      square_sum <= '0;
      sq_valid   <= 1'b0;
    end else begin
      state    <= state_next;
      sq_valid <= in_accept;
      if (cfg_write_en) begin
        epsilon <= cfg_write_data;
      end
      if (emit_done) begin
        elem_count <= '0;
        square_sum <= '0;
      end else begin
        square_sum <= square_sum_next;
        if (in_accept) begin
          elem_count <= elem_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sq <= sq_full[30:0];
    end
  end

  rmsn_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rmsn_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  rmsn_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (in_accept),
    .wr_addr   (elem_count[ADDR_W-1:0]),
    .wr_x      (x_val),
    .wr_w      (gain_val),
    .start     (emit_start),
    .len       (elem_count),
    .inv       (emit_inv),
    .done      (emit_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_val   (out_val),
    .out_last  (out_last)
  );

  // loading and emitting never overlap
  assert property (@(posedge clk) disable iff (rst) !(in_accept && out_valid))
    else $error("input request taken while a result is pending");

  // count never runs past the store depth
  assert property (@(posedge clk) disable iff (rst) elem_count <= CNT_W'(MAX_LEN))
    else $error("element count beyond vector length");

  // a closing request stops the input side
  assert property (@(posedge clk) disable iff (rst) (in_accept && last_eff) |=> in_stall)
    else $error("input still open after the vector closed");

  // taking the final result reopens the input with a clean accumulator
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_last) |=> (!in_stall && elem_count == '0))
    else $error("input not reopened after the final result");

endmodule

FILE: rtl/rmsn_div.sv
// restoring divider, one quotient bit per cycle, shared by mean and reciprocal
`timescale 1ns / 1ps

module rmsn_div
  import rmsn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [ROOT_W-1:0] rem;
  logic [SUM_W-1:0]  quo;
  logic [ROOT_W-1:0] dvs;

  logic [ROOT_W:0]   rem_sh;
  logic [ROOT_W+1:0] diff;
  logic              ge;

  assign rem_sh = {rem, quo[SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
  assign ge     = !diff[ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], ge};
      rem <= ge ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: rtl/rmsn_sqrt.sv
// digit-by-digit integer square root, two radicand bits per cycle
`timescale 1ns / 1ps

module rmsn_sqrt
  import rmsn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int STEP_W = $clog2(ROOT_STEPS);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(ROOT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= RAD_W'(req.radicand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {root[ROOT_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

FILE: rtl/rmsn_emit.sv
// pair store and result pipeline: read, x*w, times reciprocal, shift and clamp
`timescale 1ns / 1ps

module rmsn_emit
  import rmsn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic signed [15:0] wr_x,
  input  logic signed [15:0] wr_w,
  input  logic               start,
  input  logic [CNT_W-1:0]   len,
  input  logic [INV_W-1:0]   inv,
  output logic               done,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_val,
  output logic               out_last
);

  logic [31:0] mem [MAX_LEN];

  logic                     busy;
  logic [CNT_W-1:0]         k;
  logic [CNT_W-1:0]         len_r;
  logic [INV_W-1:0]         inv_r;
  logic                     advance;
  logic                     issue;

  logic                     v1, v2, v3;
  logic                     l1, l2, l3;
  logic signed [15:0]       rd_x, rd_w;
  logic signed [31:0]       xw;
  logic signed [INV_W+32:0] prod;
  logic signed [31:0]       shifted;
  logic signed [15:0]       sat_val;

  assign advance = !out_valid || !out_stall;
  assign issue   = busy && (k < len_r) && advance;
  assign done    = out_valid && !out_stall && out_last;

  // floor shift by 30, then clamp to 16-bit signed
  assign shifted = prod[61:30];

  always_comb begin
    if (shifted > SAT_MAX) begin
      sat_val = SAT_MAX[15:0];
    end else if (shifted < SAT_MIN) begin
      sat_val = SAT_MIN[15:0];
    end else begin
      sat_val = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_x, wr_w};
    end
    if (issue) begin
      {rd_x, rd_w} <= mem[k[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      k         <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (issue) begin
        k <= k + 1'b1;
      end
      if (advance) begin
        v1        <= issue;
        v2        <= v1;
        v3        <= v2;
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      len_r <= len;
      inv_r <= inv;
    end
    if (advance) begin
      l1       <= (k == len_r - 1'b1);
      l2       <= l1;
      l3       <= l2;
      out_last <= l3;
      xw       <= rd_x * rd_w;
      prod     <= xw * $signed({1'b0, inv_r});
      out_val  <= sat_val;
    end
  end

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the rms normalisation block
`timescale 1ns / 1ps

module testbench;
  import rmsn_pkg::*;

  // run control
  localparam int GAP_MAX        = 5;
  localparam int SETTLE_CYCLES  = 8;     // idle margin before an epsilon write
  localparam int END_WAIT       = 200;   // longer than one whole mean/root/recip pass
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request or result moving
  localparam int PHASE_ITEMS    = 40;

  // one (x, gain) request and one normalised result
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] gain;
    logic               last;
  } pair_req_t;

  typedef struct {
    logic signed [15:0] val;
    logic               last;
  } norm_res_t;

  // kinds of vector content
  typedef enum int {
    FLAV_WIDE,    // full-range values
    FLAV_NARROW,  // small magnitudes
    FLAV_SPIKE,   // near-zero vector with rare extremes, drives saturation
    FLAV_CORNER   // only corner values
  } flavour_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               cfg_write_en   = 1'b0;
  logic [15:0]        cfg_write_data = 16'd0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic signed [15:0] x_val          = 16'sd0;
  logic signed [15:0] gain_val       = 16'sd0;
  logic               is_last        = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic signed [15:0] out_val;
  logic               out_last;

  rms_normalize_vector DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .x_val         (x_val),
    .gain_val      (gain_val),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_val       (out_val),
    .out_last      (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: a private copy of the pair memory, the sum of squares, the
  // element count and epsilon. every accepted request goes through
  // load_pair; a closing request pushes the whole vector of results
  // ---------------------------------------------------------------------------
  logic signed [15:0] x_copy    [0:MAX_LEN-1];
  logic signed [15:0] gain_copy [0:MAX_LEN-1];
  logic [36:0]        sq_sum_model = '0;
  logic [6:0]         n_model      = '0;
  logic [15:0]        eps_model    = EPS_RESET;

  norm_res_t norm_q[$];       // results still owed by the block
  pair_req_t pair_q[$];       // requests waiting for the driver
  int        items_left      = 0;  // queued but not yet accepted
  int        pairs_taken     = 0;
  int        vectors_closed  = 0;
  int        results_checked = 0;
  int        saturated_seen  = 0;
  int        errors          = 0;

  // floor of the square root, bit by bit from the top
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = v;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  task automatic load_pair(input pair_req_t req);
    longint unsigned mean_sq;
    longint unsigned rms;
    longint unsigned inv_rms;
    longint          prod;
    longint          scaled;
    int              sq;
    int              n;
    norm_res_t       res;
    x_copy[n_model[5:0]]    = req.x;
    gain_copy[n_model[5:0]] = req.gain;
    sq           = int'(req.x) * int'(req.x);
    sq_sum_model = sq_sum_model + 37'(sq);
    n_model      = n_model + 7'd1;
    // a full memory closes the vector whether or not it was marked
    if (!req.last && n_model < MAX_LEN) return;
    n       = int'(n_model);
    mean_sq = 64'(sq_sum_model) / 64'(n) + 64'(eps_model);
    rms     = floor_root(mean_sq);
    if (rms == 0) rms = 1;
    inv_rms = (64'd1 << 28) / rms;
    for (int k = 0; k < n; k++) begin
      prod   = longint'(x_copy[k]) * longint'(gain_copy[k]) * longint'(inv_rms);
      scaled = prod >>> 30;  // floor, also for negative products
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      if (scaled == 32767 || scaled == -32768) saturated_seen++;
      res.val  = 16'(scaled);
      res.last = (k == n - 1);
      norm_q.push_back(res);
    end
    sq_sum_model = '0;
    n_model      = '0;
    vectors_closed++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: pops queued requests, holds each one while stalled and leaves a
  // random gap before the next, with runs of back-to-back requests while
  // send_steady is set
  // ---------------------------------------------------------------------------
  pair_req_t cur_req;
  int        send_gap    = 0;
  bit        send_steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap  = 0;
    end else begin
      if (in_valid && !in_stall) begin
        load_pair(cur_req);
        items_left--;
        pairs_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pair_q.size() != 0) begin
          cur_req   = pair_q.pop_front();
          x_val    <= cur_req.x;
          gain_val <= cur_req.gain;
          is_last  <= cur_req.last;
          in_valid <= 1'b1;
          if ($urandom_range(0, 15) == 0) send_steady = !send_steady;
          send_gap = send_steady ? 0 : $urandom_range(0, GAP_MAX);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every taken result against the oldest one owed, then
  // may stall for a random gap; while no result is valid it may also raise
  // a stall so the first result of a vector meets one too
  // ---------------------------------------------------------------------------
  norm_res_t want;
  int        recv_hold   = 0;
  bit        recv_steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_hold  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (norm_q.size() == 0) begin
          errors++;
          $display("%0t: result with none owed, expected nothing, actual out_val %0d out_last %0b",
                   $time, out_val, out_last);
        end else begin
          want = norm_q.pop_front();
          if (out_val !== want.val) begin
            errors++;
            $display("%0t: out_val mismatch, expected %0d, actual %0d",
                     $time, want.val, out_val);
          end
          if (out_last !== want.last) begin
            errors++;
            $display("%0t: out_last mismatch, expected %0b, actual %0b",
                     $time, want.last, out_last);
          end
        end
        if ($urandom_range(0, 15) == 0) recv_steady = !recv_steady;
        recv_hold = recv_steady ? 0 : $urandom_range(0, GAP_MAX);
      end else if (recv_hold != 0) begin
        recv_hold--;
      end else if (!out_valid && !recv_steady && $urandom_range(0, 3) == 0) begin
        recv_hold = $urandom_range(1, GAP_MAX);
      end
      out_stall <= (recv_hold != 0);
    end
  end

  // watchdog: nothing moving on either side for too long means a hang
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d requests and %0d results outstanding",
               $time, quiet_cycles, items_left, norm_q.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] pick_value(input flavour_t flav);
    logic signed [15:0] corners [0:4];
    corners = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    case (flav)
      FLAV_WIDE:   return 16'($urandom);
      FLAV_NARROW: return 16'($signed($urandom_range(0, 1024)) - 512);
      FLAV_SPIKE: begin
        if ($urandom_range(0, 11) == 0)
          return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        return 16'($signed($urandom_range(0, 16)) - 8);
      end
      default:     return corners[$urandom_range(0, 4)];
    endcase
  endfunction

  task automatic push_pair(input logic signed [15:0] x, input logic signed [15:0] gain,
                           input logic last);
    pair_req_t req;
    req.x    = x;
    req.gain = gain;
    req.last = last;
    pair_q.push_back(req);
    items_left++;
  endtask

  // a whole vector; unmarked vectors must be full length so they still close
  task automatic queue_vector(input int len, input flavour_t flav, input bit mark_end);
    flavour_t gain_flav;
    gain_flav = (flav == FLAV_SPIKE) ? FLAV_WIDE : flav;
    for (int i = 0; i < len; i++)
      push_pair(pick_value(flav), pick_value(gain_flav), mark_end && (i == len - 1));
  endtask

  // hold the sender until everything owed has arrived, then settle
  task automatic drain_block();
    do @(posedge clk); while (items_left != 0 || norm_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_epsilon(input logic [15:0] value);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    eps_model       = value;
  endtask

  task automatic random_phase(input bit with_full_vectors);
    int       added;
    int       len;
    int       pick;
    bit       mark_end;
    flavour_t flav;
    added = 0;
    if (with_full_vectors) begin
      // one unmarked full vector and one marked on its 64th element
      queue_vector(MAX_LEN, FLAV_SPIKE, 1'b0);
      queue_vector(MAX_LEN, FLAV_WIDE, 1'b1);
      added = 2 * MAX_LEN;
    end
    while (added < PHASE_ITEMS) begin
      pick     = $urandom_range(0, 9);
      mark_end = 1'b1;
      if (pick < 7) begin
        len = $urandom_range(1, 8);
      end else if (pick < 9) begin
        len = $urandom_range(9, 32);
      end else begin
        len      = MAX_LEN;
        mark_end = $urandom_range(0, 1);
      end
      flav = flavour_t'($urandom_range(0, 3));
      queue_vector(len, flav, mark_end);
      added += len;
    end
  endtask

  logic [15:0] eps_mid;

  initial begin
    eps_mid = 16'($urandom_range(2, 65534));
    do @(posedge clk); while (rst);

    // directed vectors at the reset epsilon
    push_pair(-16'sd32768, -16'sd32768, 1'b1);  // largest positive product
    push_pair(16'sd32767, -16'sd32768, 1'b1);   // largest negative product
    push_pair(16'sd0, 16'sd32767, 1'b1);        // all-zero vector, root from epsilon only
    push_pair(16'sd1, 16'sd1, 1'b1);            // tiny element, result rounds down
    push_pair(-16'sd1, 16'sd32767, 1'b1);       // tiny negative, floor rounds toward minus infinity
    push_pair(16'sd32767, 16'sd16384, 1'b0);    // mixed signs over four
    push_pair(-16'sd32768, -16'sd16384, 1'b0);
    push_pair(16'sd1, 16'sd32767, 1'b0);
    push_pair(-16'sd1, -16'sd32768, 1'b1);
    push_pair(16'sd0, 16'sd0, 1'b0);            // zeros around one element
    push_pair(16'sd4096, 16'sd16384, 1'b0);
    push_pair(16'sd0, -16'sd1, 1'b1);
    for (int i = 0; i < 20; i++)                // one spike among zeros saturates
      push_pair((i == 7) ? 16'sd32767 : 16'sd0, (i == 7) ? 16'sd32767 : 16'sd5, i == 19);
    drain_block();

    // random vectors at several epsilon settings, the extremes among them
    write_epsilon(16'd65535);
    random_phase(1'b1);
    drain_block();
    write_epsilon(16'd1);
    random_phase(1'b0);
    drain_block();
    write_epsilon(eps_mid);
    random_phase(1'b0);
    drain_block();
    write_epsilon(EPS_RESET);
    random_phase(1'b0);

    do @(posedge clk); while (items_left != 0 || norm_q.size() != 0);
    repeat (END_WAIT) @(posedge clk);

    $display("covered %0d requests in %0d vectors, %0d results checked (%0d at the clamp)",
             pairs_taken, vectors_closed, results_checked, saturated_seen);
    $display("epsilon settings: %0d, 65535, 1, %0d, %0d", EPS_RESET, eps_mid, EPS_RESET);
    if (errors == 0 && norm_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
